/* src/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// ppi_pkg
// Types and fixed constants shared by the polyphase interpolator files.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int CHANNELS      = 6;
    localparam int PHASES        = 64;
    localparam int PHASE_STEP    = 5;
    localparam int FILTER_LENGTH = 320;
    localparam int COEF_DEPTH    = (FILTER_LENGTH + 1) / 2;
    localparam int COEF_AW       = $clog2(COEF_DEPTH);
    localparam int SAMPLE_W      = 32;
    localparam int COEF_W        = 18;
    localparam int TIME_W        = 34;
    localparam int ADDR_W        = 8;
    localparam int COEF_FRAC     = 17;
    localparam int PROD_W        = SAMPLE_W + COEF_W;
    localparam int OQ_DEPTH      = 4;
    localparam int SIDE_LAT      = 4;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_LOAD   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_word;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic [TIME_W-1:0]          t_time;
    typedef t_word                      t_chan_vec [CHANNELS];

    typedef struct packed {
        logic clear;
        logic shift;
        logic rotate;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic first;
        logic zero;
    } t_lane_ctl;

    typedef struct packed {
        logic  valid;
        t_time out_time;
        logic  last;
    } t_side;

    typedef struct packed {
        t_time                             out_time;
        logic [CHANNELS-1:0][SAMPLE_W-1:0] values;
        logic                              last_of_run;
    } t_result;

endpackage

/* src/ppi_req_if.sv */
// ----------------------------------------------------------------------------
// ppi_req_if
// Request channel: sample sets and coefficient loads.
// ----------------------------------------------------------------------------
interface ppi_req_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [ppi_pkg::TIME_W-1:0]        tick_time;
    logic signed [ppi_pkg::SAMPLE_W-1:0] in_value_0;
    logic signed [ppi_pkg::SAMPLE_W-1:0] in_value_1;
    logic signed [ppi_pkg::SAMPLE_W-1:0] in_value_2;
    logic signed [ppi_pkg::SAMPLE_W-1:0] in_value_3;
    logic signed [ppi_pkg::SAMPLE_W-1:0] in_value_4;
    logic signed [ppi_pkg::SAMPLE_W-1:0] in_value_5;
    logic [ppi_pkg::ADDR_W-1:0]        coef_addr;
    logic signed [ppi_pkg::COEF_W-1:0] coef_word;

    modport source (
        output valid, action, tick_time, in_value_0, in_value_1, in_value_2,
               in_value_3, in_value_4, in_value_5, coef_addr, coef_word,
        input  ready
    );
    modport sink (
        input  valid, action, tick_time, in_value_0, in_value_1, in_value_2,
               in_value_3, in_value_4, in_value_5, coef_addr, coef_word,
        output ready
    );
endinterface

/* src/ppi_res_if.sv */
// ----------------------------------------------------------------------------
// ppi_res_if
// Result channel: PHASES interpolated sample sets per sample request.
// ----------------------------------------------------------------------------
interface ppi_res_if;
    logic                                valid;
    logic                                ready;
    logic [ppi_pkg::TIME_W-1:0]          out_time;
    logic signed [ppi_pkg::SAMPLE_W-1:0] out_value_0;
    logic signed [ppi_pkg::SAMPLE_W-1:0] out_value_1;
    logic signed [ppi_pkg::SAMPLE_W-1:0] out_value_2;
    logic signed [ppi_pkg::SAMPLE_W-1:0] out_value_3;
    logic signed [ppi_pkg::SAMPLE_W-1:0] out_value_4;
    logic signed [ppi_pkg::SAMPLE_W-1:0] out_value_5;
    logic                                last_of_run;

    modport source (
        output valid, out_time, out_value_0, out_value_1, out_value_2,
               out_value_3, out_value_4, out_value_5, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_time, out_value_0, out_value_1, out_value_2,
               out_value_3, out_value_4, out_value_5, last_of_run,
        output ready
    );
endinterface

/* src/ppi_cell.sv */
// ----------------------------------------------------------------------------
// ppi_cell
// One history stage: holds one sample set, shifts in from the newer
// neighbor or rotates in from the older neighbor.
// ----------------------------------------------------------------------------
module ppi_cell (
    input  logic               i_clk,
    input  ppi_pkg::t_cell_ctl i_ctl,
    input  ppi_pkg::t_chan_vec i_prev,
    input  ppi_pkg::t_chan_vec i_next,
    output ppi_pkg::t_chan_vec o_sample
);

    ppi_pkg::t_chan_vec r_sample;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < ppi_pkg::CHANNELS; c++) begin
            if (i_ctl.clear) begin
                r_sample[c] <= '0;
            end else if (i_ctl.shift) begin
                r_sample[c] <= i_prev[c];
            end else if (i_ctl.rotate) begin
                r_sample[c] <= i_next[c];
            end
        end
    end

    assign o_sample = r_sample;

endmodule

/* src/ppi_lane.sv */
// ----------------------------------------------------------------------------
// ppi_lane
// One channel datapath: multiply, accumulate over taps, scale and round,
// add the offset back and saturate.
// ----------------------------------------------------------------------------
module ppi_lane #(
    parameter int ACC_W = 53
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppi_pkg::t_lane_ctl i_ctl,
    input  ppi_pkg::t_coef     i_coef,
    input  ppi_pkg::t_word     i_sample,
    input  ppi_pkg::t_word     i_offset,
    output ppi_pkg::t_word     o_value
);

    localparam int SC_W = ACC_W + $clog2(ppi_pkg::PHASES) + 1;
    localparam int PW   = ppi_pkg::PROD_W;
    localparam int SW   = ppi_pkg::SAMPLE_W;
    localparam logic signed [SC_W-1:0] HALF     = SC_W'(1) << (ppi_pkg::COEF_FRAC - 1);
    localparam logic signed [SC_W-1:0] SCALE    = SC_W'(ppi_pkg::PHASES);
    localparam logic signed [SC_W-1:0] SAT_MAX  =
        {{(SC_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [SC_W-1:0] SAT_MIN  =
        {{(SC_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

    logic signed [PW-1:0]    r_prod;
    logic                    r_pvalid;
    logic                    r_pfirst;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SC_W-1:0]  r_round;
    ppi_pkg::t_word          r_value;

    logic signed [PW-1:0]    n_prod;
    logic signed [ACC_W-1:0] w_prod_ext;
    logic signed [SC_W-1:0]  w_acc_ext;
    logic signed [SC_W-1:0]  w_scaled;
    logic signed [SC_W-1:0]  w_biased;
    logic signed [SC_W-1:0]  w_total;

    assign n_prod     = i_ctl.zero ? '0 : PW'(i_sample * i_coef);
    assign w_prod_ext = {{(ACC_W - PW){r_prod[PW-1]}}, r_prod};
    assign w_acc_ext  = {{(SC_W - ACC_W){r_acc[ACC_W-1]}}, r_acc};
    assign w_scaled   = w_acc_ext * SCALE;
    assign w_biased   = w_scaled + HALF;
    assign w_total    = r_round + {{(SC_W - SW){i_offset[SW-1]}}, i_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_pfirst <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.valid;
            r_pfirst <= i_ctl.first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_pvalid) begin
            r_acc <= r_pfirst ? w_prod_ext : r_acc + w_prod_ext;
        end
        r_round <= w_biased >>> ppi_pkg::COEF_FRAC;
        if (w_total > SAT_MAX) begin
            r_value <= SAT_MAX[SW-1:0];
        end else if (w_total < SAT_MIN) begin
            r_value <= SAT_MIN[SW-1:0];
        end else begin
            r_value <= w_total[SW-1:0];
        end
    end

    assign o_value = r_value;

endmodule

/* src/ppi_oq.sv */
// ----------------------------------------------------------------------------
// ppi_oq
// Output queue: holds finished results until the result channel takes them.
// ----------------------------------------------------------------------------
module ppi_oq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ppi_pkg::t_result i_data,
    output logic             o_pop,
    ppi_res_if.source        o_res
);

    localparam int DEPTH = ppi_pkg::OQ_DEPTH;
    localparam int QA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QC_W  = $clog2(DEPTH + 1);

    ppi_pkg::t_result r_mem [DEPTH];
    logic [QA_W-1:0]  r_wr;
    logic [QA_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_count;
    ppi_pkg::t_result w_head;

    assign o_pop  = o_res.valid && o_res.ready;
    assign w_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QA_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (o_pop) begin
                r_rd <= (r_rd == QA_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + QC_W'(i_push) - QC_W'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_res.valid       = (r_count != '0);
    assign o_res.out_time    = w_head.out_time;
    assign o_res.out_value_0 = w_head.values[0];
    assign o_res.out_value_1 = w_head.values[1];
    assign o_res.out_value_2 = w_head.values[2];
    assign o_res.out_value_3 = w_head.values[3];
    assign o_res.out_value_4 = w_head.values[4];
    assign o_res.out_value_5 = w_head.values[5];
    assign o_res.last_of_run = w_head.last_of_run;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QC_W'(DEPTH)) || o_pop)
        else $error("output queue overflow");
`endif

endmodule

/* src/polyphase_interpolator_5_to_64.sv */
// ----------------------------------------------------------------------------
// polyphase_interpolator_5_to_64
// Six-channel polyphase FIR interpolator with folded symmetric coefficients.
// ----------------------------------------------------------------------------
// A coefficient load request does not make the block busy. A sample request
// occupies the block until its PHASES * TAPS_PER_PHASE taps (320 by default)
// are issued: while taps are issued, the history, a ring of TAPS_PER_PHASE
// cells, rotates one step per cycle past six multiply-accumulate lanes and
// the coefficient memory supplies one tap per cycle. Results pass through the
// lane registers into a four-entry output queue; new results are started only
// while queue space is free, so a stalled sink pauses the tap sequence. The
// next request is taken once all taps of the last result have been issued.
// Coefficient words read before they are written are undefined.
// ----------------------------------------------------------------------------
module polyphase_interpolator_5_to_64 #(
    parameter int TAPS_PER_PHASE = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppi_req_if.sink   i_req,
    ppi_res_if.source o_res
);

    localparam int CH     = ppi_pkg::CHANNELS;
    localparam int PH     = ppi_pkg::PHASES;
    localparam int FL     = ppi_pkg::FILTER_LENGTH;
    localparam int CD     = ppi_pkg::COEF_DEPTH;
    localparam int CAW    = ppi_pkg::COEF_AW;
    localparam int SW     = ppi_pkg::SAMPLE_W;
    localparam int PH_W   = $clog2(PH);
    localparam int TP_W   = $clog2(TAPS_PER_PHASE);
    localparam int TAP_W  = $clog2(PH * TAPS_PER_PHASE + FL);
    localparam int CNT_W  = $clog2(ppi_pkg::OQ_DEPTH + 1);
    localparam int ACC_W  = ppi_pkg::PROD_W + $clog2(TAPS_PER_PHASE);
    localparam int BACK   = (PH - (ppi_pkg::PHASE_STEP % PH)) % PH;
    localparam int SL     = ppi_pkg::SIDE_LAT;

    logic               r_busy;
    logic               r_first_seen;
    logic [TP_W-1:0]    r_tap;
    logic [PH_W-1:0]    r_idx;
    logic [PH_W-1:0]    r_phase;
    ppi_pkg::t_time     r_time;
    logic [CNT_W-1:0]   r_cnt;
    ppi_pkg::t_word     r_offset [CH];
    ppi_pkg::t_coef     r_coef [CD];
    ppi_pkg::t_coef     r_coef_q;
    ppi_pkg::t_lane_ctl r_a_ctl;
    ppi_pkg::t_chan_vec r_a_samp;
    ppi_pkg::t_side     r_side [SL + 1];

    logic [PH_W:0]      n_phase;
    ppi_pkg::t_chan_vec w_in;
    ppi_pkg::t_chan_vec w_diff;
    ppi_pkg::t_chan_vec w_cell [TAPS_PER_PHASE];
    ppi_pkg::t_chan_vec w_prev [TAPS_PER_PHASE];
    ppi_pkg::t_chan_vec w_lane_value;
    ppi_pkg::t_cell_ctl w_cell_ctl;
    ppi_pkg::t_result   w_push_data;
    logic               w_accept;
    logic               w_sample;
    logic               w_load;
    logic               w_issue;
    logic               w_start;
    logic               w_last_tap;
    logic               w_last_idx;
    logic               w_pop;
    logic [TAP_W-1:0]   w_tap;
    logic [TAP_W-1:0]   w_fold;
    logic [TAP_W-1:0]   w_sel;
    logic               w_zero;

    assign w_in[0] = i_req.in_value_0;
    assign w_in[1] = i_req.in_value_1;
    assign w_in[2] = i_req.in_value_2;
    assign w_in[3] = i_req.in_value_3;
    assign w_in[4] = i_req.in_value_4;
    assign w_in[5] = i_req.in_value_5;

    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_sample    = w_accept && (i_req.action == ppi_pkg::ACTION_SAMPLE);
    assign w_load      = w_accept && (i_req.action == ppi_pkg::ACTION_LOAD);

    // remove the offset, saturate to 32 bits
    always_comb begin
        logic signed [SW:0] d;
        for (int c = 0; c < CH; c++) begin
            d = {w_in[c][SW-1], w_in[c]} - {r_offset[c][SW-1], r_offset[c]};
            if (d[SW] != d[SW-1]) begin
                w_diff[c] = d[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
            end else begin
                w_diff[c] = d[SW-1:0];
            end
        end
    end

    assign w_last_tap = (r_tap == TP_W'(TAPS_PER_PHASE - 1));
    assign w_last_idx = (r_idx == PH_W'(PH - 1));
    assign w_issue    = r_busy && ((r_tap != '0) || (r_cnt < CNT_W'(ppi_pkg::OQ_DEPTH)));
    assign w_start    = w_issue && (r_tap == '0);

    assign w_cell_ctl.clear  = w_sample && !r_first_seen;
    assign w_cell_ctl.shift  = w_sample && r_first_seen;
    assign w_cell_ctl.rotate = w_issue;

    for (genvar j = 0; j < TAPS_PER_PHASE; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_prev[j] = w_diff;
        end else begin : g_body
            assign w_prev[j] = w_cell[j-1];
        end
        ppi_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_cell_ctl),
            .i_prev   (w_prev[j]),
            .i_next   (w_cell[(j + 1) % TAPS_PER_PHASE]),
            .o_sample (w_cell[j])
        );
    end

    // fold the tap index onto the stored half of the symmetric filter
    assign w_tap  = TAP_W'(r_phase) + TAP_W'(r_tap) * TAP_W'(PH);
    assign w_fold = TAP_W'(FL - 1) - w_tap;
    assign w_sel  = (w_tap >= TAP_W'(CD)) ? w_fold : w_tap;
    assign w_zero = (w_tap >= TAP_W'(FL)) || (w_sel >= TAP_W'(CD));

    always_comb begin
        n_phase = {1'b0, r_phase} + (PH_W + 1)'(BACK);
        if (n_phase >= (PH_W + 1)'(PH)) begin
            n_phase = n_phase - (PH_W + 1)'(PH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_first_seen <= 1'b0;
            r_tap        <= '0;
            r_idx        <= '0;
            r_phase      <= '0;
            r_cnt        <= '0;
            r_a_ctl      <= '0;
            for (int s = 0; s <= SL; s++) begin
                r_side[s].valid <= 1'b0;
            end
        end else begin
            if (w_sample) begin
                r_busy       <= 1'b1;
                r_first_seen <= 1'b1;
                r_tap        <= '0;
                r_idx        <= '0;
                r_phase      <= '0;
            end else if (w_issue) begin
                if (w_last_tap) begin
                    r_tap   <= '0;
                    r_idx   <= r_idx + 1'b1;
                    r_phase <= n_phase[PH_W-1:0];
                    if (w_last_idx) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_tap <= r_tap + 1'b1;
                end
            end
            r_cnt         <= r_cnt + CNT_W'(w_start) - CNT_W'(w_pop);
            r_a_ctl.valid <= w_issue;
            r_a_ctl.first <= (r_tap == '0);
            r_a_ctl.zero  <= w_zero;
            r_side[0].valid    <= w_issue && w_last_tap;
            r_side[0].out_time <= r_time;
            r_side[0].last     <= w_last_idx;
            for (int s = 1; s <= SL; s++) begin
                r_side[s].valid    <= r_side[s-1].valid;
                r_side[s].out_time <= r_side[s-1].out_time;
                r_side[s].last     <= r_side[s-1].last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_time <= i_req.tick_time;
        end else if (w_issue && w_last_tap) begin
            r_time <= r_time - 1'b1;
        end
        if (w_sample && !r_first_seen) begin
            for (int c = 0; c < CH; c++) begin
                r_offset[c] <= w_in[c];
            end
        end
        if (w_load && (i_req.coef_addr < ppi_pkg::ADDR_W'(CD))) begin
            r_coef[i_req.coef_addr[CAW-1:0]] <= i_req.coef_word;
        end
        r_coef_q <= r_coef[w_sel[CAW-1:0]];
        r_a_samp <= w_cell[0];
    end

    for (genvar c = 0; c < CH; c++) begin : g_lane
        ppi_lane #(
            .ACC_W (ACC_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (r_a_ctl),
            .i_coef   (r_coef_q),
            .i_sample (r_a_samp[c]),
            .i_offset (r_offset[c]),
            .o_value  (w_lane_value[c])
        );
        assign w_push_data.values[c] = w_lane_value[c];
    end

    assign w_push_data.out_time    = r_side[SL].out_time;
    assign w_push_data.last_of_run = r_side[SL].last;

    ppi_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_side[SL].valid),
        .i_data  (w_push_data),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ppi_pkg::OQ_DEPTH))
        else $error("result credit count exceeds queue depth");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> ($past(r_idx) == PH_W'(PH - 1))
                       && ($past(r_tap) == TP_W'(TAPS_PER_PHASE - 1)))
        else $error("run ended before its last tap");

    a_push_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side[SL].valid |-> (r_cnt != '0))
        else $error("result pushed without reserved space");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap <= TP_W'(TAPS_PER_PHASE - 1))
        else $error("tap counter out of range");
`endif

endmodule

/* tb/polyphase_interpolator_5_to_64_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_interpolator_5_to_64_tb
// Self-checking bench for the six-channel polyphase interpolator. It loads the
// folded coefficient table, sends directed and random sample sets and
// coefficient loads under random idling on both channels, predicts all 64
// interpolated points of every sample set and checks each point on arrival.
// ----------------------------------------------------------------------------
module polyphase_interpolator_5_to_64_tb;

    localparam int             TAPS     = 5;
    localparam int             CHN      = ppi_pkg::CHANNELS;
    localparam int             PHS      = ppi_pkg::PHASES;
    localparam int             CDEPTH   = ppi_pkg::COEF_DEPTH;
    localparam ppi_pkg::t_word W_MIN    = 32'sh8000_0000;
    localparam ppi_pkg::t_word W_MAX    = 32'sh7FFF_FFFF;
    localparam ppi_pkg::t_coef COEF_MIN = 18'sh20000;
    localparam ppi_pkg::t_coef COEF_MAX = 18'sh1FFFF;
    localparam ppi_pkg::t_time TIME_MAX = {ppi_pkg::TIME_W{1'b1}};

    typedef struct {
        bit                         drain;
        logic                       action;
        ppi_pkg::t_time             tick;
        ppi_pkg::t_chan_vec         val;
        logic [ppi_pkg::ADDR_W-1:0] addr;
        ppi_pkg::t_coef             word;
    } t_req_item;

    logic i_clk;
    logic i_rst_n;

    ppi_req_if req_if ();
    ppi_res_if res_if ();

    polyphase_interpolator_5_to_64 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_req_item          backlog [$];
    ppi_pkg::t_result   due_points [$];
    t_req_item          cur_req;
    int                 req_gap;
    int                 req_calm;
    int                 res_stall;
    int                 res_calm;
    int                 mismatches;
    ppi_pkg::t_chan_vec base_vals;

    ppi_pkg::t_word     hist [TAPS][CHN];
    ppi_pkg::t_word     chan_offset [CHN];
    ppi_pkg::t_coef     coef_model [CDEPTH];
    int                 ring_slot;
    bit                 primed;

    ppi_pkg::t_result   want;
    ppi_pkg::t_word     seen_vals [CHN];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic ppi_pkg::t_word clip32(longint v);
        if (v > longint'(W_MAX)) return W_MAX;
        if (v < longint'(W_MIN)) return W_MIN;
        return ppi_pkg::t_word'(v);
    endfunction

    function automatic int pick_gap(inout int calm, input int long_max);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3) calm = $urandom_range(20, 80);
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(13, long_max);
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        $display("mismatch %s: got %0h, want %0h", what, got, exp_val);
        mismatches++;
    endtask

    task automatic run_interpolation(t_req_item it);
        int               slot;
        int               phase;
        int               s;
        int               t;
        longint           acc;
        longint           r;
        ppi_pkg::t_result pt;
        slot = ring_slot;
        if (!primed) begin
            primed = 1'b1;
            for (int c = 0; c < CHN; c++) chan_offset[c] = it.val[c];
            for (int k = 0; k < TAPS; k++)
                for (int c = 0; c < CHN; c++) hist[k][c] = '0;
        end else begin
            for (int c = 0; c < CHN; c++)
                hist[slot][c] = clip32(longint'(it.val[c]) - longint'(chan_offset[c]));
        end
        phase = 0;
        for (int i = 0; i < PHS; i++) begin
            pt.out_time = it.tick - ppi_pkg::t_time'(i);
            for (int c = 0; c < CHN; c++) begin
                acc = 0;
                for (int k = 0; k < TAPS; k++) begin
                    s = (slot + TAPS - k) % TAPS;
                    t = phase + PHS * k;
                    if (t >= CDEPTH) t = ppi_pkg::FILTER_LENGTH - 1 - t;
                    acc += longint'(hist[s][c]) * longint'(coef_model[t]);
                end
                acc = acc * PHS;
                r = (acc + (longint'(1) << (ppi_pkg::COEF_FRAC - 1))) >>> ppi_pkg::COEF_FRAC;
                r += longint'(chan_offset[c]);
                pt.values[c] = clip32(r);
            end
            pt.last_of_run = (i == PHS - 1);
            due_points.push_back(pt);
            phase = (phase + PHS - ppi_pkg::PHASE_STEP) % PHS;
        end
        ring_slot = (slot + 1) % TAPS;
    endtask

    task automatic apply_request(t_req_item it);
        if (it.action == ppi_pkg::ACTION_LOAD) begin
            if (it.addr < CDEPTH) coef_model[it.addr] = it.word;
        end else begin
            run_interpolation(it);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) apply_request(cur_req);
            if (req_if.valid && !req_if.ready) begin
                // hold the request until taken
            end else if (req_gap > 0) begin
                req_gap--;
                req_if.valid <= 1'b0;
            end else if (backlog.size() > 0 && backlog[0].drain) begin
                req_if.valid <= 1'b0;
                if (due_points.size() == 0) void'(backlog.pop_front());
            end else if (backlog.size() > 0) begin
                cur_req = backlog.pop_front();
                req_if.valid      <= 1'b1;
                req_if.action     <= cur_req.action;
                req_if.tick_time  <= cur_req.tick;
                req_if.in_value_0 <= cur_req.val[0];
                req_if.in_value_1 <= cur_req.val[1];
                req_if.in_value_2 <= cur_req.val[2];
                req_if.in_value_3 <= cur_req.val[3];
                req_if.in_value_4 <= cur_req.val[4];
                req_if.in_value_5 <= cur_req.val[5];
                req_if.coef_addr  <= cur_req.addr;
                req_if.coef_word  <= cur_req.word;
                req_gap = pick_gap(req_calm, 60);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (res_stall > 0) begin
            res_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            res_stall = pick_gap(res_calm, 24);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen_vals[0] = res_if.out_value_0;
            seen_vals[1] = res_if.out_value_1;
            seen_vals[2] = res_if.out_value_2;
            seen_vals[3] = res_if.out_value_3;
            seen_vals[4] = res_if.out_value_4;
            seen_vals[5] = res_if.out_value_5;
            if (due_points.size() == 0) begin
                flag_mismatch("result with nothing due", res_if.out_time, '0);
            end else begin
                want = due_points.pop_front();
                if (res_if.out_time !== want.out_time)
                    flag_mismatch("out_time", res_if.out_time, want.out_time);
                for (int c = 0; c < CHN; c++)
                    if (seen_vals[c] !== want.values[c])
                        flag_mismatch($sformatf("out_value_%0d", c), seen_vals[c],
                                      want.values[c]);
                if (res_if.last_of_run !== want.last_of_run)
                    flag_mismatch("last_of_run", res_if.last_of_run, want.last_of_run);
            end
        end
    end

    task automatic queue_load(int addr, ppi_pkg::t_coef word);
        t_req_item it;
        it.drain  = 1'b0;
        it.action = ppi_pkg::ACTION_LOAD;
        it.tick   = ppi_pkg::t_time'({$urandom, $urandom});
        for (int c = 0; c < CHN; c++) it.val[c] = ppi_pkg::t_word'($urandom);
        it.addr   = addr[ppi_pkg::ADDR_W-1:0];
        it.word   = word;
        backlog.push_back(it);
    endtask

    task automatic queue_sample(ppi_pkg::t_time tk, ppi_pkg::t_chan_vec v);
        t_req_item it;
        it.drain  = 1'b0;
        it.action = ppi_pkg::ACTION_SAMPLE;
        it.tick   = tk;
        it.val    = v;
        it.addr   = ppi_pkg::ADDR_W'($urandom);
        it.word   = ppi_pkg::t_coef'($urandom);
        backlog.push_back(it);
    endtask

    task automatic queue_drain();
        t_req_item it;
        it.drain  = 1'b1;
        it.action = ppi_pkg::ACTION_SAMPLE;
        it.tick   = '0;
        it.addr   = '0;
        it.word   = '0;
        for (int c = 0; c < CHN; c++) it.val[c] = '0;
        backlog.push_back(it);
    endtask

    function automatic ppi_pkg::t_coef pick_coef(bit wild);
        int r;
        r = $urandom_range(0, 99);
        if (!wild && r < 80)
            return ppi_pkg::t_coef'(int'($urandom_range(0, 4096)) - 2048);
        if (r < 90) return ppi_pkg::t_coef'($urandom);
        return (r % 2) ? COEF_MAX : COEF_MIN;
    endfunction

    function automatic ppi_pkg::t_word pick_value(int c);
        int r;
        int span;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            span = 1 << $urandom_range(2, 20);
            return base_vals[c] + ppi_pkg::t_word'(int'($urandom_range(0, 2 * span)) - span);
        end
        if (r < 75) return ppi_pkg::t_word'($urandom);
        if (r < 90) begin
            case ($urandom_range(0, 3))
                0: return W_MIN;
                1: return W_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return base_vals[c];
    endfunction

    task automatic queue_table(bit wild);
        for (int a = 0; a < CDEPTH; a++) queue_load(a, pick_coef(wild));
    endtask

    task automatic queue_random(int count);
        ppi_pkg::t_chan_vec v;
        int                 addr;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 12) begin
                addr = ($urandom_range(0, 99) < 85) ? $urandom_range(0, CDEPTH - 1)
                                                     : $urandom_range(CDEPTH, 255);
                queue_load(addr, pick_coef($urandom_range(0, 3) == 0));
            end else begin
                for (int c = 0; c < CHN; c++) v[c] = pick_value(c);
                queue_sample(ppi_pkg::t_time'({$urandom, $urandom}), v);
            end
            if (n % 120 == 119) queue_drain();
        end
    endtask

    initial begin
        ppi_pkg::t_chan_vec v;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ppi_pkg::ACTION_SAMPLE;
        req_if.tick_time  = '0;
        req_if.in_value_0 = '0;
        req_if.in_value_1 = '0;
        req_if.in_value_2 = '0;
        req_if.in_value_3 = '0;
        req_if.in_value_4 = '0;
        req_if.in_value_5 = '0;
        req_if.coef_addr  = '0;
        req_if.coef_word  = '0;
        res_if.ready      = 1'b0;
        req_gap    = 0;
        req_calm   = 0;
        res_stall  = 0;
        res_calm   = 0;
        mismatches = 0;
        ring_slot  = 0;
        primed     = 1'b0;
        for (int k = 0; k < TAPS; k++)
            for (int c = 0; c < CHN; c++) hist[k][c] = '0;
        for (int c = 0; c < CHN; c++) chan_offset[c] = '0;

        queue_table(1'b0);

        base_vals = '{W_MIN, W_MAX, 32'sd0, -32'sd1, 32'sd1, 32'sh5A5A_A5A5};
        queue_sample('0, base_vals);
        v = '{W_MAX, W_MIN, 32'sd0, 32'sd0, 32'sd1, 32'sh5A5A_A5A6};
        queue_sample(TIME_MAX, v);
        queue_load(0, COEF_MAX);
        queue_load(CDEPTH - 1, COEF_MIN);
        queue_load(PHS, COEF_MIN);
        queue_load(ppi_pkg::FILTER_LENGTH - 1 - 3 * PHS - 33, COEF_MAX);
        queue_load(CDEPTH, COEF_MAX);
        queue_load(255, COEF_MIN);
        queue_sample(ppi_pkg::t_time'(1), v);
        queue_sample(ppi_pkg::t_time'(64), base_vals);
        queue_sample(ppi_pkg::t_time'(65), base_vals);
        v = '{W_MIN, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX};
        queue_sample(TIME_MAX - 1, v);
        for (int n = 0; n < 3; n++) begin
            for (int c = 0; c < CHN; c++) v[c] = ppi_pkg::t_word'($urandom);
            queue_sample(ppi_pkg::t_time'({$urandom, $urandom}), v);
        end
        queue_drain();
        queue_load(0, '0);
        queue_load(CDEPTH - 1, ppi_pkg::t_coef'(18'sd100));
        v = '{-32'sd1, 32'sd0, W_MAX, W_MIN, 32'sh0001_0000, -32'sh0001_0000};
        queue_sample(ppi_pkg::t_time'(32'hFFFF_FFFF), v);

        queue_random(200);
        queue_drain();
        queue_random(130);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (backlog.size() != 0 || req_if.valid) @(posedge i_clk);
        while (due_points.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
